[hdl/umr_pkg.sv]
// Shared types, constants and helpers for the multichannel ultrasonic ranger.
// No dependencies; imported by every module of the block.
package umr_pkg;

  localparam int NUM_CHANNELS = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_DONE,
    PH_TOUT
  } phase_t;

  typedef enum logic [2:0] {
    CFG_CHANNEL_ENABLE = 3'd0,
    CFG_TRIGGER_WIDTH  = 3'd1,
    CFG_ECHO_TIMEOUT   = 3'd2,
    CFG_MAX_ECHO       = 3'd3,
    CFG_SLOT_PERIOD    = 3'd4
  } cfg_index_t;

  localparam logic [3:0]  CHANNEL_ENABLE_RST = 4'd0;
  localparam logic [7:0]  TRIGGER_WIDTH_RST  = 8'd10;
  localparam logic [15:0] ECHO_TIMEOUT_RST   = 16'd40000;
  localparam logic [15:0] MAX_ECHO_RST       = 16'd35000;
  localparam logic [15:0] SLOT_PERIOD_RST    = 16'd50000;

  // floor(x/58) = (x*36158) >> 21 and floor(x/148) = (x*56680) >> 23 for 16-bit x
  localparam logic [15:0] CM_RECIP   = 16'd36158;
  localparam int          CM_SHIFT   = 21;
  localparam logic [15:0] INCH_RECIP = 16'd56680;
  localparam int          INCH_SHIFT = 23;

  typedef struct packed {
    logic [3:0]  channel_enable;
    logic [7:0]  trigger_width;
    logic [15:0] echo_timeout;
    logic [15:0] max_echo;
    logic [15:0] slot_period;
  } cfg_t;

  // one tick's slot result, handed from the slot controller to the range stage
  typedef struct packed {
    logic [3:0]  trigger_lines;
    logic [1:0]  active_channel;
    logic        done;
    logic [1:0]  channel;
    logic        valid;
    logic [15:0] etime;
    logic [1:0]  query_channel;
  } sample_t;

  typedef struct packed {
    logic       found;
    logic [1:0] channel;
  } chan_pick_t;

  // first enabled channel at or after start, wrapping
  function automatic chan_pick_t find_enabled(logic [3:0] enable, logic [1:0] start);
    chan_pick_t pick;
    logic [1:0] c;
    pick.found   = 1'b0;
    pick.channel = start;
    for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
      c = start + 2'(k);
      if (enable[c]) begin
        pick.found   = 1'b1;
        pick.channel = c;
      end
    end
    return pick;
  endfunction

endpackage

[hdl/multichannel_ultrasonic_ranger.sv]
// Top level of the multichannel ultrasonic ranger: config registers, input register,
// handshake and the two processing stages. Depends on umr_pkg, umr_slot_ctrl,
// umr_range_store.
//
//   channel | signals                                     | transfer when
//   --------+---------------------------------------------+-----------------------
//   in      | in_valid, in_stall, echo_levels, query_channel | in_valid && !in_stall
//   out     | out_valid, out_stall, 10 result fields       | out_valid && !out_stall
//   cfg     | cfg_write, cfg_index, cfg_data               | cfg_write
//
// One tick item per clock sustained while out_stall is low; results pass to the outputs
// through the input register (loaded on the transfer edge), then the slot state stage,
// then the range/store stage with the output register.
// The slot state stage is the only loop: its state updates in the cycle an item passes.
// Reset (rst, synchronous) restores register defaults, idle phase and zero readings.
// out_stall holds the pipeline; in_stall rises only when the input register cannot move.
module multichannel_ultrasonic_ranger import umr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         echo_levels,
  input  logic [1:0]         query_channel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         trigger_lines,
  output logic [1:0]         active_channel,
  output logic               sample_done,
  output logic [1:0]         sample_channel,
  output logic               sample_valid,
  output logic [15:0]        echo_time,
  output logic signed [11:0] sample_cm,
  output logic signed [9:0]  sample_inch,
  output logic signed [11:0] query_cm,
  output logic signed [9:0]  query_inch
);

  cfg_t       cfg;
  logic [3:0] in_echo;
  logic [1:0] in_query;
  logic       a_valid, b_valid;
  logic       move_a, move_b, move_o;
  sample_t    sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable <= CHANNEL_ENABLE_RST;
      cfg.trigger_width  <= TRIGGER_WIDTH_RST;
      cfg.echo_timeout   <= ECHO_TIMEOUT_RST;
      cfg.max_echo       <= MAX_ECHO_RST;
      cfg.slot_period    <= SLOT_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHANNEL_ENABLE: cfg.channel_enable <= cfg_data[3:0];
        CFG_TRIGGER_WIDTH:  cfg.trigger_width  <= cfg_data[7:0];
        CFG_ECHO_TIMEOUT:   cfg.echo_timeout   <= cfg_data;
        CFG_MAX_ECHO:       cfg.max_echo       <= cfg_data;
        CFG_SLOT_PERIOD:    cfg.slot_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // each stage moves when the one after it is empty or moving on
  assign move_o   = b_valid && (!out_valid || !out_stall);
  assign move_b   = a_valid && (!b_valid || move_o);
  assign in_stall = a_valid && !move_b;
  assign move_a   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move_a)      a_valid <= 1'b1;
      else if (move_b) a_valid <= 1'b0;
      if (move_b)      b_valid <= 1'b1;
      else if (move_o) b_valid <= 1'b0;
      if (move_o)                       out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_a) begin
      in_echo  <= echo_levels;
      in_query <= query_channel;
    end
  end

  umr_slot_ctrl u_slot (
    .clk           (clk),
    .rst           (rst),
    .step          (move_b),
    .cfg           (cfg),
    .echo_levels   (in_echo),
    .query_channel (in_query),
    .sample        (sample)
  );

  umr_range_store u_range (
    .clk            (clk),
    .rst            (rst),
    .load           (move_o),
    .channel_enable (cfg.channel_enable),
    .sample         (sample),
    .trigger_lines  (trigger_lines),
    .active_channel (active_channel),
    .sample_done    (sample_done),
    .sample_channel (sample_channel),
    .sample_valid   (sample_valid),
    .echo_time      (echo_time),
    .sample_cm      (sample_cm),
    .sample_inch    (sample_inch),
    .query_cm       (query_cm),
    .query_inch     (query_inch)
  );

  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(trigger_lines))
    else $error("more than one trigger line driven");

  a_done_no_trig: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_done |-> trigger_lines == 4'd0)
    else $error("trigger driven on slot end");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_done |-> echo_time == 16'd0 && sample_cm == 12'sd0 &&
                                  !sample_valid)
    else $error("sample fields set without slot end");

  a_valid_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> sample_done && echo_time <= cfg.max_echo &&
                                  sample_cm >= 12'sd0)
    else $error("valid sample outside limit");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !move_b |=> a_valid && $stable(in_echo) && $stable(in_query))
    else $error("input register lost a waiting item");

endmodule

[hdl/umr_slot_ctrl.sv]
// Slot sequencer: trigger, echo edge capture, timeout and round-robin channel step.
// Depends on umr_pkg; registers one sample_t per processed tick.
module umr_slot_ctrl import umr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  logic [3:0] echo_levels,
  input  logic [1:0] query_channel,
  output sample_t    sample
);

  phase_t      phase, phase_next;
  logic [15:0] slot_ticks, slot_ticks_next;
  logic [15:0] rise_count, rise_count_next;
  logic [15:0] fall_count, fall_count_next;
  logic [1:0]  channel, channel_next;
  logic        previous_echo, previous_echo_next;

  logic [7:0]  tw;
  logic [15:0] sp;
  logic [15:0] t;
  logic        e;
  logic        trig;
  chan_pick_t  pick_cur, pick_nxt;
  sample_t     sample_next;

  always_comb begin
    tw = (cfg.trigger_width == 8'd0) ? 8'd1 : cfg.trigger_width;
    sp = (cfg.slot_period == 16'd0) ? 16'd1 : cfg.slot_period;

    phase_next      = phase;
    slot_ticks_next = slot_ticks;
    rise_count_next = rise_count;
    fall_count_next = fall_count;
    channel_next    = channel;
    trig            = 1'b0;
    sample_next     = '0;
    pick_nxt        = '0;

    pick_cur = find_enabled(cfg.channel_enable, channel);
    if (phase == PH_IDLE && pick_cur.found) begin
      channel_next    = pick_cur.channel;
      phase_next      = PH_TRIG;
      slot_ticks_next = 16'd0;
      rise_count_next = 16'd0;
      fall_count_next = 16'd0;
    end

    e = echo_levels[channel_next];
    t = slot_ticks_next - 16'(tw);

    if (phase_next != PH_IDLE) begin
      if (phase_next == PH_TRIG) begin
        trig = 1'b1;
        if ({1'b0, slot_ticks_next} + 17'd1 >= {9'd0, tw}) phase_next = PH_WAIT;
      end else if (phase_next == PH_WAIT) begin
        if (!previous_echo && e) begin
          rise_count_next = t;
        end else if (previous_echo && !e) begin
          fall_count_next = t;
          phase_next      = PH_DONE;
        end
        if (phase_next == PH_WAIT && t >= cfg.echo_timeout) begin
          rise_count_next = 16'd0;
          fall_count_next = cfg.echo_timeout;
          phase_next      = PH_TOUT;
        end
      end

      if ({1'b0, slot_ticks_next} + 17'd1 >= {1'b0, sp}) begin
        // slot over; an unfinished trigger or wait counts as a timeout
        if (phase_next == PH_TRIG || phase_next == PH_WAIT) begin
          rise_count_next = 16'd0;
          fall_count_next = cfg.echo_timeout;
          phase_next      = PH_TOUT;
        end
        sample_next.done    = 1'b1;
        sample_next.channel = channel_next;
        sample_next.etime   = fall_count_next - rise_count_next;
        sample_next.valid   = (phase_next == PH_DONE) && (sample_next.etime <= cfg.max_echo);
        pick_nxt = find_enabled(cfg.channel_enable, channel_next + 2'd1);
        if (pick_nxt.found) channel_next = pick_nxt.channel;
        phase_next      = PH_IDLE;
        slot_ticks_next = 16'd0;
      end else begin
        slot_ticks_next = slot_ticks_next + 16'd1;
      end
    end

    previous_echo_next = e;

    sample_next.trigger_lines  = (trig && !sample_next.done) ? (4'd1 << channel_next) : 4'd0;
    sample_next.active_channel = channel_next;
    sample_next.query_channel  = query_channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      slot_ticks    <= 16'd0;
      rise_count    <= 16'd0;
      fall_count    <= 16'd0;
      channel       <= 2'd0;
      previous_echo <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      slot_ticks    <= slot_ticks_next;
      rise_count    <= rise_count_next;
      fall_count    <= fall_count_next;
      channel       <= channel_next;
      previous_echo <= previous_echo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) sample <= sample_next;
  end

endmodule

[hdl/umr_range_store.sv]
// Distance conversion (cm, inch by reciprocal multiply), per-channel reading store
// and query lookup. Depends on umr_pkg; output fields are registered here.
module umr_range_store import umr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [3:0]         channel_enable,
  input  sample_t            sample,
  output logic [3:0]         trigger_lines,
  output logic [1:0]         active_channel,
  output logic               sample_done,
  output logic [1:0]         sample_channel,
  output logic               sample_valid,
  output logic [15:0]        echo_time,
  output logic signed [11:0] sample_cm,
  output logic signed [9:0]  sample_inch,
  output logic signed [11:0] query_cm,
  output logic signed [9:0]  query_inch
);

  logic signed [11:0] stored_cm   [NUM_CHANNELS];
  logic signed [9:0]  stored_inch [NUM_CHANNELS];

  logic [31:0]        cm_prod, inch_prod;
  logic signed [11:0] cm_val, qcm;
  logic signed [9:0]  inch_val, qinch;
  logic               bypass;

  always_comb begin
    cm_prod   = 32'(sample.etime) * 32'(CM_RECIP);
    inch_prod = 32'(sample.etime) * 32'(INCH_RECIP);

    if (!sample.done) begin
      cm_val   = '0;
      inch_val = '0;
    end else if (sample.valid) begin
      cm_val   = {1'b0, cm_prod[CM_SHIFT +: 11]};
      inch_val = {1'b0, inch_prod[INCH_SHIFT +: 9]};
    end else begin
      cm_val   = '1;
      inch_val = '1;
    end

    // a reading finished this tick is visible to the same tick's query
    bypass = sample.done && (sample.channel == sample.query_channel);
    if (!channel_enable[sample.query_channel]) begin
      qcm   = '1;
      qinch = '1;
    end else if (bypass) begin
      qcm   = cm_val;
      qinch = inch_val;
    end else begin
      qcm   = stored_cm[sample.query_channel];
      qinch = stored_inch[sample.query_channel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stored_cm[i]   <= '0;
        stored_inch[i] <= '0;
      end
    end else if (load && sample.done) begin
      stored_cm[sample.channel]   <= cm_val;
      stored_inch[sample.channel] <= inch_val;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trigger_lines  <= sample.trigger_lines;
      active_channel <= sample.active_channel;
      sample_done    <= sample.done;
      sample_channel <= sample.channel;
      sample_valid   <= sample.valid;
      echo_time      <= sample.etime;
      sample_cm      <= cm_val;
      sample_inch    <= inch_val;
      query_cm       <= qcm;
      query_inch     <= qinch;
    end
  end

endmodule

[bench/multichannel_ultrasonic_ranger_test.sv]
// Self-checking bench for multichannel_ultrasonic_ranger: directed ticks, then
// randomized echo pulse trains under several register settings. Needs umr_pkg.
`timescale 1ns / 1ps

module multichannel_ultrasonic_ranger_test;
  import umr_pkg::*;

  typedef struct packed {
    logic [3:0] echo;
    logic [1:0] qch;
  } echo_tick_t;

  typedef struct packed {
    logic [3:0]  trigger_lines;
    logic [1:0]  active_channel;
    logic        sample_done;
    logic [1:0]  sample_channel;
    logic        sample_valid;
    logic [15:0] echo_time;
    logic [11:0] sample_cm;
    logic [9:0]  sample_inch;
    logic [11:0] query_cm;
    logic [9:0]  query_inch;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] echo_levels = '0;
  logic [1:0] query_channel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] trigger_lines;
  logic [1:0] active_channel;
  logic sample_done;
  logic [1:0] sample_channel;
  logic sample_valid;
  logic [15:0] echo_time;
  logic signed [11:0] sample_cm;
  logic signed [9:0] sample_inch;
  logic signed [11:0] query_cm;
  logic signed [9:0] query_inch;

  multichannel_ultrasonic_ranger u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .echo_levels(echo_levels), .query_channel(query_channel),
    .out_valid(out_valid), .out_stall(out_stall),
    .trigger_lines(trigger_lines), .active_channel(active_channel),
    .sample_done(sample_done), .sample_channel(sample_channel),
    .sample_valid(sample_valid), .echo_time(echo_time),
    .sample_cm(sample_cm), .sample_inch(sample_inch),
    .query_cm(query_cm), .query_inch(query_inch)
  );

  always #6 clk = ~clk;

  echo_tick_t tick_queue[$];
  reading_t   expected_readings[$];
  int         ticks_sent = 0;
  int         readings_seen = 0;
  int         errors = 0;

  // register shadow
  logic [3:0]  r_enable      = CHANNEL_ENABLE_RST;
  logic [7:0]  r_trig_width  = TRIGGER_WIDTH_RST;
  logic [15:0] r_timeout     = ECHO_TIMEOUT_RST;
  logic [15:0] r_max_echo    = MAX_ECHO_RST;
  logic [15:0] r_slot_period = SLOT_PERIOD_RST;

  // ranging state
  phase_t             p_phase     = PH_IDLE;
  logic [15:0]        p_slot_ticks = '0;
  logic [15:0]        p_rise      = '0;
  logic [15:0]        p_fall      = '0;
  logic [1:0]         p_channel   = '0;
  logic               p_prev_echo = 1'b0;
  logic signed [11:0] p_cm   [NUM_CHANNELS] = '{default: '0};
  logic signed [9:0]  p_inch [NUM_CHANNELS] = '{default: '0};

  function automatic int next_enabled(logic [1:0] start);
    logic [1:0] c;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      c = start + 2'(k);
      if (r_enable[c]) return int'(c);
    end
    return -1;
  endfunction

  // one tick of the ranging controller; updates the shadow state
  function automatic reading_t predict_reading(logic [3:0] levels, logic [1:0] qch);
    reading_t r;
    int tw, sp, s, t, pick;
    logic e, trig, done;
    logic [15:0] etime;
    r = '0;
    trig = 1'b0;
    done = 1'b0;
    tw = (r_trig_width == 0) ? 1 : int'(r_trig_width);
    sp = (r_slot_period == 0) ? 1 : int'(r_slot_period);
    if (p_phase == PH_IDLE) begin
      pick = next_enabled(p_channel);
      if (pick >= 0) begin
        p_channel = pick[1:0];
        p_phase = PH_TRIG;
        p_slot_ticks = '0;
        p_rise = '0;
        p_fall = '0;
      end
    end
    e = levels[p_channel];
    if (p_phase != PH_IDLE) begin
      s = int'(p_slot_ticks);
      if (p_phase == PH_TRIG) begin
        trig = 1'b1;
        if (s + 1 >= tw) p_phase = PH_WAIT;
      end else if (p_phase == PH_WAIT) begin
        t = (s - tw) & 32'hFFFF;
        if (!p_prev_echo && e) begin
          p_rise = t[15:0];
        end else if (p_prev_echo && !e) begin
          p_fall = t[15:0];
          p_phase = PH_DONE;
        end
        if (p_phase == PH_WAIT && t >= int'(r_timeout)) begin
          p_rise = '0;
          p_fall = r_timeout;
          p_phase = PH_TOUT;
        end
      end
      if (s + 1 >= sp) begin
        // slot ends inside trigger or wait: treated as a timeout
        if (p_phase == PH_TRIG || p_phase == PH_WAIT) begin
          p_rise = '0;
          p_fall = r_timeout;
          p_phase = PH_TOUT;
        end
        done = 1'b1;
        etime = p_fall - p_rise;
        r.sample_done = 1'b1;
        r.sample_channel = p_channel;
        r.echo_time = etime;
        r.sample_valid = (p_phase == PH_DONE) && (etime <= r_max_echo);
        if (r.sample_valid) begin
          r.sample_cm = 12'(etime / 16'd58);
          r.sample_inch = 10'(etime / 16'd148);
        end else begin
          r.sample_cm = '1;
          r.sample_inch = '1;
        end
        p_cm[p_channel] = r.sample_cm;
        p_inch[p_channel] = r.sample_inch;
        pick = next_enabled(p_channel + 2'd1);
        if (pick >= 0) p_channel = pick[1:0];
        p_phase = PH_IDLE;
        p_slot_ticks = '0;
      end else begin
        p_slot_ticks = 16'(s + 1);
      end
    end
    p_prev_echo = e;
    r.trigger_lines = (trig && !done) ? (4'b0001 << p_channel) : 4'b0000;
    r.active_channel = p_channel;
    if (r_enable[qch]) begin
      r.query_cm = p_cm[qch];
      r.query_inch = p_inch[qch];
    end else begin
      r.query_cm = '1;
      r.query_inch = '1;
    end
    return r;
  endfunction

  function automatic string fmt_reading(reading_t r);
    return $sformatf("trig=%h act=%0d done=%0d ch=%0d ok=%0d time=%0d cm=%0d in=%0d qcm=%0d qin=%0d",
                     r.trigger_lines, r.active_channel, r.sample_done, r.sample_channel,
                     r.sample_valid, r.echo_time, $signed(r.sample_cm), $signed(r.sample_inch),
                     $signed(r.query_cm), $signed(r.query_inch));
  endfunction

  // sender: no idling while ticks 450..699 go out
  echo_tick_t next_tick;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(echo_levels, query_channel));
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() > 0 &&
            ((ticks_sent >= 450 && ticks_sent < 700) || $urandom_range(99) >= 16)) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          echo_levels <= next_tick.echo;
          query_channel <= next_tick.qch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: one long hold-off after 300 transfers, calm window 500..699
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  reading_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {trigger_lines, active_channel, sample_done, sample_channel, sample_valid,
               echo_time, sample_cm, sample_inch, query_cm, query_inch};
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected reading: %s", fmt_reading(got));
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at reading %0d", readings_seen);
              $display("  expected %s", fmt_reading(want));
              $display("  actual   %s", fmt_reading(got));
            end
          end
        end
        readings_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (readings_seen >= 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 120;
        out_stall <= 1'b1;
      end else if (readings_seen >= 500 && readings_seen < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 16);
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CHANNEL_ENABLE: r_enable = val[3:0];
      CFG_TRIGGER_WIDTH:  r_trig_width = val[7:0];
      CFG_ECHO_TIMEOUT:   r_timeout = val;
      CFG_MAX_ECHO:       r_max_echo = val;
      CFG_SLOT_PERIOD:    r_slot_period = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] en, logic [7:0] tw, logic [15:0] tout,
                            logic [15:0] maxe, logic [15:0] sp);
    wait_drained();
    write_reg(CFG_CHANNEL_ENABLE, {12'h000, en});
    write_reg(CFG_TRIGGER_WIDTH, {8'h00, tw});
    write_reg(CFG_ECHO_TIMEOUT, tout);
    write_reg(CFG_MAX_ECHO, maxe);
    write_reg(CFG_SLOT_PERIOD, sp);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // echo pulse trains: each channel toggles after a random run length
  logic [3:0] gen_level = '0;
  int         gen_run [NUM_CHANNELS] = '{default: 0};

  task automatic run_phase(logic [3:0] en, logic [7:0] tw, logic [15:0] tout,
                           logic [15:0] maxe, logic [15:0] sp, int n, int max_run,
                           int noise_pct);
    echo_tick_t it;
    set_config(en, tw, tout, maxe, sp);
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (gen_run[c] == 0) begin
          gen_level[c] = ~gen_level[c];
          gen_run[c] = $urandom_range(max_run, 1);
        end
        gen_run[c]--;
      end
      it.echo = ($urandom_range(99) < noise_pct) ? 4'($urandom_range(15)) : gen_level;
      it.qch = 2'($urandom_range(3));
      tick_queue.push_back(it);
    end
  endtask

  initial begin
    echo_tick_t it;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults, nothing enabled: block stays idle
    for (int k = 0; k < 4; k++) begin
      it.echo = k[0] ? 4'hF : 4'h0;
      it.qch = 2'(k);
      tick_queue.push_back(it);
    end

    // zero trigger width and zero slot period: every tick is a whole slot
    set_config(4'hF, 8'd0, 16'd0, 16'd0, 16'd0);
    for (int k = 0; k < 5; k++) begin
      it.echo = k[0] ? 4'h0 : 4'hF;
      it.qch = 2'(k);
      tick_queue.push_back(it);
    end

    // one clean echo on channel 0 while channel 3 holds the slot; longest timeout and limit
    set_config(4'b1001, 8'd1, 16'hFFFF, 16'hFFFF, 16'd16);
    for (int k = 0; k < 16; k++) begin
      it.echo = {k[0], 2'($urandom_range(3)), (k >= 3 && k <= 12)};
      it.qch = 2'(k);
      tick_queue.push_back(it);
    end

    run_phase(4'hF, 8'd3, 16'd60, 16'hFFFF, 16'd90, 150, 40, 5);
    run_phase(4'($urandom_range(15, 1)), 8'($urandom_range(8, 1)),
              16'($urandom_range(200, 20)), 16'($urandom_range(200)),
              16'($urandom_range(250, 60)), 150, 50, 10);
    run_phase(4'b0110, 8'd10, 16'd300, 16'd250, 16'd400, 220, 180, 5);
    // widest trigger: slots cut short in the wait
    run_phase(4'b1000, 8'd255, 16'hFFFF, 16'hFFFF, 16'd300, 120, 60, 10);
    // longest slot never finishes here; the next phase ends it mid-slot
    run_phase(4'($urandom_range(15, 1)), 8'($urandom_range(255)), 16'd30, 16'd100,
              16'hFFFF, 80, 30, 10);
    // everything disabled while a slot runs
    run_phase(4'h0, 8'd1, 16'd1, 16'd0, 16'd150, 60, 20, 10);
    for (int p = 0; p < 4; p++) begin
      run_phase(4'($urandom_range(15)), 8'($urandom_range(12)),
                16'($urandom_range(250)), 16'($urandom_range(400)),
                16'($urandom_range(300)), 90, $urandom_range(150, 4), 10);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

endmodule

[multichannel_ultrasonic_ranger.f]
hdl/umr_pkg.sv
hdl/umr_slot_ctrl.sv
hdl/umr_range_store.sv
hdl/multichannel_ultrasonic_ranger.sv
bench/multichannel_ultrasonic_ranger_test.sv
